// ===== rtl/nfb_pkg.sv =====
// Shared types, codes and helper functions of the neighborhood fingerprint bound core.
package nfb_pkg;

   localparam int unsigned REQ_W   = 88;
   localparam int unsigned RSP_W   = 80;
   localparam int unsigned ID_W    = 32;
   localparam int unsigned VTX_W   = 10;
   localparam int unsigned LOAD_W  = 16;
   localparam int unsigned SUM_W   = 19;
   localparam int unsigned READS_W = 12;
   localparam int unsigned CNT8_W  = 8;

   localparam logic [31:0] HASH_MUL_A = 32'h7feb352d;
   localparam logic [31:0] HASH_MUL_B = 32'h846ca68b;

   localparam logic KIND_NEIGHBOR = 1'b0;
   localparam logic KIND_QUERY    = 1'b1;

   localparam logic [1:0] ERR_OK     = 2'd0;
   localparam logic [1:0] ERR_RANGE  = 2'd1;
   localparam logic [1:0] ERR_FULL   = 2'd2;
   localparam logic [1:0] ERR_DEGREE = 2'd3;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_HASH1, ST_HASH2, ST_CREAD, ST_CWRITE, ST_FCHECK,
      ST_SWEEP, ST_DRAIN, ST_BUILD_OUT, ST_ZAP, ST_ERR_OUT, ST_QCHECK, ST_SCAN,
      ST_SCAN_DRAIN, ST_BOUND, ST_DECIDE, ST_RWORD, ST_RLOAD, ST_RBIT, ST_RACC,
      ST_QUERY_OUT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLEAR, OP_LATCH, OP_HASH1, OP_HASH2, OP_CREAD, OP_CWRITE,
      OP_FCHECK, OP_SWEEP, OP_DRAIN, OP_BUILD_OUT, OP_ERR_OUT, OP_QCHECK, OP_SCAN,
      OP_SCAN_DRAIN, OP_BOUND, OP_DECIDE, OP_RWORD, OP_RLOAD, OP_RNEXT, OP_RISSUE,
      OP_RACC, OP_QUERY_OUT
   } op_type;

   typedef struct packed {
      logic       sweep_last;
      logic       word_last;
      logic [1:0] build_err;
      logic       range_err;
      logic       bound_low;
      logic       ovf_any;
      logic       common_zero;
      logic       hit;
      logic       rsp_free;
      logic       in_last;
   } status_type;

   function automatic logic [6:0] pop64(input logic [63:0] v);
      logic [3:0] grp [8];
      logic [6:0] tot;
      tot = '0;
      for (int g = 0; g < 8; g++) begin
         grp[g] = '0;
         for (int b = 0; b < 8; b++) begin
            grp[g] = grp[g] + 4'(v[8*g+b]);
         end
         tot = tot + 7'(grp[g]);
      end
      return tot;
   endfunction

endpackage

// ===== rtl/nfb_ctrl.sv =====
// Sequencer for neighbor builds, finish sweeps and bound queries.
module nfb_ctrl
   import nfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_kind,
   input  status_type status,
   output logic       req_tready,
   output op_type     op
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op         = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            op = OP_CLEAR;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op       = OP_LATCH;
               state_in = (req_kind == KIND_QUERY) ? ST_QCHECK : ST_HASH1;
            end
         end
         ST_HASH1: begin
            op       = OP_HASH1;
            state_in = ST_HASH2;
         end
         ST_HASH2: begin
            op       = OP_HASH2;
            state_in = ST_CREAD;
         end
         ST_CREAD: begin
            op       = OP_CREAD;
            state_in = ST_CWRITE;
         end
         ST_CWRITE: begin
            op       = OP_CWRITE;
            state_in = status.in_last ? ST_FCHECK : ST_IDLE;
         end
         ST_FCHECK: begin
            op       = OP_FCHECK;
            state_in = (status.build_err != ERR_OK) ? ST_ZAP : ST_SWEEP;
         end
         ST_ZAP: begin
            op = OP_CLEAR;
            if (status.sweep_last) state_in = ST_ERR_OUT;
         end
         ST_SWEEP: begin
            op = OP_SWEEP;
            if (status.sweep_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            op       = OP_DRAIN;
            state_in = ST_BUILD_OUT;
         end
         ST_BUILD_OUT: begin
            if (status.rsp_free) begin
               op       = OP_BUILD_OUT;
               state_in = ST_IDLE;
            end
         end
         ST_ERR_OUT: begin
            if (status.rsp_free) begin
               op       = OP_ERR_OUT;
               state_in = ST_IDLE;
            end
         end
         ST_QCHECK: begin
            op       = OP_QCHECK;
            state_in = status.range_err ? ST_ERR_OUT : ST_SCAN;
         end
         ST_SCAN: begin
            op = OP_SCAN;
            if (status.word_last) state_in = ST_SCAN_DRAIN;
         end
         ST_SCAN_DRAIN: begin
            op       = OP_SCAN_DRAIN;
            state_in = ST_BOUND;
         end
         ST_BOUND: begin
            op       = OP_BOUND;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            op       = OP_DECIDE;
            state_in = (status.bound_low || status.ovf_any) ? ST_QUERY_OUT : ST_RWORD;
         end
         ST_RWORD: begin
            op       = OP_RWORD;
            state_in = ST_RLOAD;
         end
         ST_RLOAD: begin
            op       = OP_RLOAD;
            state_in = ST_RBIT;
         end
         ST_RBIT: begin
            if (status.common_zero) begin
               op       = OP_RNEXT;
               state_in = status.word_last ? ST_QUERY_OUT : ST_RWORD;
            end else begin
               op       = OP_RISSUE;
               state_in = ST_RACC;
            end
         end
         ST_RACC: begin
            op       = OP_RACC;
            state_in = status.hit ? ST_QUERY_OUT : ST_RBIT;
         end
         ST_QUERY_OUT: begin
            if (status.rsp_free) begin
               op       = OP_QUERY_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// ===== rtl/nfb_dp.sv =====
// Datapath: hash, bucket counters, fingerprint stores and query arithmetic.
module nfb_dp
   import nfb_pkg::*;
#(
   parameter int          MAX_VERTICES = 1024,
   parameter int          WORDS        = 32,
   parameter int          BUCKETS      = 2048,
   parameter int          COUNT_DEPTH  = 65536,
   parameter logic [31:0] MAX_DEGREE   = 32'd65535
)(
   input  logic                clock,
   input  logic                reset,
   input  op_type              op,
   input  logic                req_kind,
   input  logic [ID_W-1:0]     req_neighbor_id,
   input  logic                req_last,
   input  logic [VTX_W-1:0]    req_left_vertex,
   input  logic [VTX_W-1:0]    req_right_vertex,
   input  logic [31:0]         req_required_common,
   input  logic                rsp_ready,
   output status_type          status,
   output logic                rsp_valid,
   output logic                rsp_answer_kind,
   output logic [VTX_W-1:0]    rsp_built_vertex,
   output logic [LOAD_W-1:0]   rsp_neighborhood_degree,
   output logic [LOAD_W-1:0]   rsp_largest_load,
   output logic                rsp_saturated_count,
   output logic [SUM_W-1:0]    rsp_match_sum,
   output logic [READS_W-1:0]  rsp_reads_done,
   output logic                rsp_may_reach,
   output logic [1:0]          rsp_error_code
);

   localparam int BKT_W  = $clog2(BUCKETS);
   localparam int OCW    = BKT_W + 1;
   localparam int VB_W   = $clog2(MAX_VERTICES + 1);
   localparam int VI_W   = $clog2(MAX_VERTICES);
   localparam int OCC_W  = $clog2(MAX_VERTICES * WORDS);
   localparam int CA_W   = $clog2(COUNT_DEPTH);
   localparam int CS_W   = $clog2(COUNT_DEPTH + 1);
   localparam int WI_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int META_W = CS_W + 1 + LOAD_W;
   localparam int PROD_W = SUM_W + LOAD_W;

   // memories
   logic [LOAD_W-1:0] cnt_mem  [BUCKETS];
   logic [63:0]       occ_mem  [MAX_VERTICES*WORDS];
   logic [CNT8_W-1:0] cs_mem   [COUNT_DEPTH];
   logic [META_W-1:0] meta_mem [MAX_VERTICES];

   logic [LOAD_W-1:0] cnt_rd_ff;
   logic [63:0]       occ_a_ff, occ_b_ff;
   logic [CNT8_W-1:0] cs_a_ff, cs_b_ff;
   logic [META_W-1:0] meta_a_ff, meta_b_ff;

   logic              cnt_we, cnt_re;
   logic [BKT_W-1:0]  cnt_wa, cnt_ra;
   logic [LOAD_W-1:0] cnt_wd;
   logic              occ_we, occ_re;
   logic [OCC_W-1:0]  occ_wa, occ_ra_a, occ_ra_b;
   logic [63:0]       occ_wd;
   logic              cs_we, cs_re;
   logic [CA_W-1:0]   cs_wa, cs_ra_a, cs_ra_b;
   logic [CNT8_W-1:0] cs_wd;
   logic              meta_we, meta_re;
   logic [VI_W-1:0]   meta_wa, meta_ra_a, meta_ra_b;
   logic [META_W-1:0] meta_wd;

   // control registers
   logic [BKT_W-1:0]  sweep_idx_ff, sweep_idx_in;
   logic              proc_v_ff, proc_v_in;
   logic              scan_v_ff, scan_v_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VB_W-1:0]   built_ff, built_in;
   logic [CS_W-1:0]   append_ff, append_in;
   logic [LOAD_W-1:0] degree_ff, degree_in;
   logic [LOAD_W-1:0] maxload_ff, maxload_in;
   logic              excess_ff, excess_in;
   logic [OCW-1:0]    occupied_ff, occupied_in;

   // payload registers
   logic                kind_ff, kind_in;
   logic                last_ff, last_in;
   logic [ID_W-1:0]     nid_ff, nid_in;
   logic [VTX_W-1:0]    left_ff, left_in;
   logic [VTX_W-1:0]    right_ff, right_in;
   logic [31:0]         reqc_ff, reqc_in;
   logic [31:0]         h1_ff, h1_in;
   logic [31:0]         h2_ff, h2_in;
   logic [BKT_W-1:0]    bucket_ff, bucket_in;
   logic                skip_ff, skip_in;
   logic [BKT_W-1:0]    proc_b_ff, proc_b_in;
   logic [63:0]         word_acc_ff, word_acc_in;
   logic                ovf_ff, ovf_in;
   logic [1:0]          err_ff, err_in;
   logic [CS_W-1:0]     vstart_ff, vstart_in;
   logic [WI_W-1:0]     word_idx_ff, word_idx_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [READS_W-1:0]  reads_ff, reads_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [CS_W-1:0]     lc_ff, lc_in, rc_ff, rc_in;
   logic [63:0]         a_ff, a_in, c_ff, c_in, common_ff, common_in;
   logic                may_ff, may_in;
   logic                r_kind_ff, r_kind_in;
   logic [VTX_W-1:0]    r_bv_ff, r_bv_in;
   logic [LOAD_W-1:0]   r_deg_ff, r_deg_in;
   logic [LOAD_W-1:0]   r_load_ff, r_load_in;
   logic                r_sat_ff, r_sat_in;
   logic [SUM_W-1:0]    r_match_ff, r_match_in;
   logic [READS_W-1:0]  r_reads_ff, r_reads_in;
   logic                r_may_ff, r_may_in;
   logic [1:0]          r_err_ff, r_err_in;

   // combinational helpers
   logic [31:0]         x0, x1, x2;
   logic [BKT_W-1:0]    bucket_c;
   logic                deg_full;
   logic                bucket_in_row, proc_in_row;
   logic [1:0]          build_err;
   logic [LOAD_W-1:0]   cnt_inc;
   logic [LOAD_W-1:0]   load_a, load_b, min_load;
   logic [63:0]         low_mask;
   logic [CNT8_W-1:0]   min_cnt;
   logic [SUM_W:0]      racc_sum;
   logic                hit;
   logic [OCC_W-1:0]    row_l, row_r, row_b;

   assign x0       = nid_ff ^ (nid_ff >> 16);
   assign x1       = h1_ff ^ (h1_ff >> 15);
   assign x2       = h2_ff ^ (h2_ff >> 16);
   assign bucket_c = x2[BKT_W-1:0];
   assign deg_full = ((33'(degree_ff) + 33'd1) > {1'b0, MAX_DEGREE})
                     || (degree_ff == {LOAD_W{1'b1}});
   assign bucket_in_row = ((BKT_W+7)'(bucket_ff) >> 6) < (BKT_W+7)'(WORDS);
   assign proc_in_row   = ((BKT_W+7)'(proc_b_ff) >> 6) < (BKT_W+7)'(WORDS);
   assign cnt_inc  = cnt_rd_ff + LOAD_W'(1);
   assign build_err = excess_ff ? ERR_DEGREE :
                      ((32'(built_ff) >= 32'(MAX_VERTICES)) ||
                       ((33'(append_ff) + 33'(occupied_ff)) > 33'(COUNT_DEPTH))) ?
                      ERR_FULL : ERR_OK;
   assign load_a   = meta_a_ff[META_W-1 -: LOAD_W];
   assign load_b   = meta_b_ff[META_W-1 -: LOAD_W];
   assign min_load = (load_a < load_b) ? load_a : load_b;
   assign low_mask = (common_ff & (~common_ff + 64'd1)) - 64'd1;
   assign min_cnt  = (cs_a_ff < cs_b_ff) ? cs_a_ff : cs_b_ff;
   assign racc_sum = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(min_cnt);
   assign hit      = 33'(racc_sum) >= {1'b0, reqc_ff};
   assign row_l    = OCC_W'(OCC_W'(VI_W'(left_ff)) * OCC_W'(WORDS));
   assign row_r    = OCC_W'(OCC_W'(VI_W'(right_ff)) * OCC_W'(WORDS));
   assign row_b    = OCC_W'(OCC_W'(VI_W'(built_ff)) * OCC_W'(WORDS));

   always_comb begin
      status.sweep_last  = sweep_idx_ff == BKT_W'(BUCKETS - 1);
      status.word_last   = word_idx_ff == WI_W'(WORDS - 1);
      status.build_err   = build_err;
      status.range_err   = (32'(left_ff) >= 32'(built_ff)) || (32'(right_ff) >= 32'(built_ff));
      status.bound_low   = prod_ff < PROD_W'(reqc_ff);
      status.ovf_any     = meta_a_ff[CS_W] | meta_b_ff[CS_W];
      status.common_zero = common_ff == 64'd0;
      status.hit         = hit;
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
      status.in_last     = last_ff;
   end

   always_comb begin
      sweep_idx_in = sweep_idx_ff;
      proc_v_in    = 1'b0;
      scan_v_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      built_in     = built_ff;
      append_in    = append_ff;
      degree_in    = degree_ff;
      maxload_in   = maxload_ff;
      excess_in    = excess_ff;
      occupied_in  = occupied_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      nid_in       = nid_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      reqc_in      = reqc_ff;
      h1_in        = h1_ff;
      h2_in        = h2_ff;
      bucket_in    = bucket_ff;
      skip_in      = skip_ff;
      proc_b_in    = proc_b_ff;
      word_acc_in  = word_acc_ff;
      ovf_in       = ovf_ff;
      err_in       = err_ff;
      vstart_in    = vstart_ff;
      word_idx_in  = word_idx_ff;
      sum_in       = sum_ff;
      reads_in     = reads_ff;
      prod_in      = prod_ff;
      lc_in        = lc_ff;
      rc_in        = rc_ff;
      a_in         = a_ff;
      c_in         = c_ff;
      common_in    = common_ff;
      may_in       = may_ff;
      r_kind_in    = r_kind_ff;
      r_bv_in      = r_bv_ff;
      r_deg_in     = r_deg_ff;
      r_load_in    = r_load_ff;
      r_sat_in     = r_sat_ff;
      r_match_in   = r_match_ff;
      r_reads_in   = r_reads_ff;
      r_may_in     = r_may_ff;
      r_err_in     = r_err_ff;

      cnt_we   = 1'b0;
      cnt_re   = 1'b0;
      cnt_wa   = sweep_idx_ff;
      cnt_ra   = sweep_idx_ff;
      cnt_wd   = '0;
      occ_we   = 1'b0;
      occ_re   = 1'b0;
      occ_wa   = OCC_W'(row_b + OCC_W'(proc_b_ff >> 6));
      occ_wd   = word_acc_ff;
      occ_ra_a = OCC_W'(row_l + OCC_W'(word_idx_ff));
      occ_ra_b = OCC_W'(row_r + OCC_W'(word_idx_ff));
      cs_we    = 1'b0;
      cs_re    = 1'b0;
      cs_wa    = CA_W'(append_ff);
      cs_wd    = (cnt_rd_ff > LOAD_W'(255)) ? {CNT8_W{1'b1}} : cnt_rd_ff[CNT8_W-1:0];
      cs_ra_a  = CA_W'(lc_ff + CS_W'(pop64(a_ff & low_mask)));
      cs_ra_b  = CA_W'(rc_ff + CS_W'(pop64(c_ff & low_mask)));
      meta_we  = 1'b0;
      meta_re  = 1'b0;
      meta_wa  = VI_W'(built_ff);
      meta_wd  = {maxload_ff, ovf_ff, vstart_ff};
      meta_ra_a = VI_W'(left_ff);
      meta_ra_b = VI_W'(right_ff);

      // finish sweep: one counter per cycle, one row word every 64 buckets
      if (proc_v_ff) begin
         if ((cnt_rd_ff != '0) && proc_in_row) begin
            word_acc_in = word_acc_ff | (64'd1 << proc_b_ff[5:0]);
            cs_we       = 1'b1;
            append_in   = append_ff + CS_W'(1);
            if (cnt_rd_ff > LOAD_W'(255)) ovf_in = 1'b1;
         end
         if (proc_b_ff[5:0] == 6'd63) begin
            occ_we      = proc_in_row;
            occ_wd      = word_acc_in;
            word_acc_in = '0;
         end
      end

      // coarse scan accumulate
      if (scan_v_ff) begin
         sum_in   = sum_ff + SUM_W'(pop64(occ_a_ff & occ_b_ff));
         reads_in = reads_ff + READS_W'(1);
      end

      case (op)
         OP_CLEAR: begin
            cnt_we       = 1'b1;
            sweep_idx_in = sweep_idx_ff + BKT_W'(1);
            degree_in    = '0;
            maxload_in   = '0;
            excess_in    = 1'b0;
            occupied_in  = '0;
         end
         OP_LATCH: begin
            kind_in  = req_kind;
            last_in  = req_last;
            nid_in   = req_neighbor_id;
            left_in  = req_left_vertex;
            right_in = req_right_vertex;
            reqc_in  = req_required_common;
         end
         OP_HASH1: h1_in = x0 * HASH_MUL_A;
         OP_HASH2: h2_in = x1 * HASH_MUL_B;
         OP_CREAD: begin
            bucket_in = bucket_c;
            cnt_re    = 1'b1;
            cnt_ra    = bucket_c;
            skip_in   = deg_full;
            if (deg_full) excess_in = 1'b1;
         end
         OP_CWRITE: begin
            if (!skip_ff) begin
               cnt_we    = 1'b1;
               cnt_wa    = bucket_ff;
               cnt_wd    = cnt_inc;
               degree_in = degree_ff + LOAD_W'(1);
               if (cnt_inc > maxload_ff) maxload_in = cnt_inc;
               if ((cnt_rd_ff == '0) && bucket_in_row) occupied_in = occupied_ff + OCW'(1);
            end
         end
         OP_FCHECK: begin
            err_in      = build_err;
            vstart_in   = append_ff;
            word_acc_in = '0;
            ovf_in      = 1'b0;
         end
         OP_SWEEP: begin
            cnt_we       = 1'b1;
            cnt_re       = 1'b1;
            sweep_idx_in = sweep_idx_ff + BKT_W'(1);
            proc_v_in    = 1'b1;
            proc_b_in    = sweep_idx_ff;
         end
         OP_DRAIN: begin
         end
         OP_BUILD_OUT: begin
            meta_we      = 1'b1;
            built_in     = built_ff + VB_W'(1);
            rsp_valid_in = 1'b1;
            r_kind_in    = KIND_NEIGHBOR;
            r_bv_in      = VTX_W'(built_ff);
            r_deg_in     = degree_ff;
            r_load_in    = maxload_ff;
            r_sat_in     = ovf_ff;
            r_match_in   = '0;
            r_reads_in   = '0;
            r_may_in     = 1'b0;
            r_err_in     = ERR_OK;
            degree_in    = '0;
            maxload_in   = '0;
            excess_in    = 1'b0;
            occupied_in  = '0;
         end
         OP_ERR_OUT: begin
            rsp_valid_in = 1'b1;
            r_kind_in    = kind_ff;
            r_bv_in      = '0;
            r_deg_in     = '0;
            r_load_in    = '0;
            r_sat_in     = 1'b0;
            r_match_in   = '0;
            r_reads_in   = '0;
            r_may_in     = 1'b0;
            r_err_in     = err_ff;
         end
         OP_QCHECK: begin
            err_in      = ERR_RANGE;
            meta_re     = 1'b1;
            word_idx_in = '0;
            sum_in      = '0;
            reads_in    = '0;
            may_in      = 1'b0;
         end
         OP_SCAN: begin
            occ_re      = 1'b1;
            word_idx_in = word_idx_ff + WI_W'(1);
            scan_v_in   = 1'b1;
         end
         OP_SCAN_DRAIN: word_idx_in = '0;
         OP_BOUND: begin
            prod_in = PROD_W'(sum_ff) * PROD_W'(min_load);
            lc_in   = meta_a_ff[CS_W-1:0];
            rc_in   = meta_b_ff[CS_W-1:0];
         end
         OP_DECIDE: begin
            may_in      = !status.bound_low && status.ovf_any;
            word_idx_in = '0;
            if (!status.bound_low && !status.ovf_any) sum_in = '0;
         end
         OP_RWORD: occ_re = 1'b1;
         OP_RLOAD: begin
            a_in      = occ_a_ff;
            c_in      = occ_b_ff;
            common_in = occ_a_ff & occ_b_ff;
         end
         OP_RNEXT: begin
            lc_in       = lc_ff + CS_W'(pop64(a_ff));
            rc_in       = rc_ff + CS_W'(pop64(c_ff));
            word_idx_in = word_idx_ff + WI_W'(1);
         end
         OP_RISSUE: cs_re = 1'b1;
         OP_RACC: begin
            sum_in    = racc_sum[SUM_W-1:0];
            reads_in  = reads_ff + READS_W'(1);
            common_in = common_ff & (common_ff - 64'd1);
            if (hit) may_in = 1'b1;
         end
         OP_QUERY_OUT: begin
            rsp_valid_in = 1'b1;
            r_kind_in    = KIND_QUERY;
            r_bv_in      = '0;
            r_deg_in     = '0;
            r_load_in    = '0;
            r_sat_in     = 1'b0;
            r_match_in   = sum_ff;
            r_reads_in   = reads_ff;
            r_may_in     = may_ff;
            r_err_in     = ERR_OK;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
      if (cnt_re) cnt_rd_ff <= cnt_mem[cnt_ra];
   end

   always_ff @(posedge clock) begin
      if (occ_we) occ_mem[occ_wa] <= occ_wd;
      if (occ_re) begin
         occ_a_ff <= occ_mem[occ_ra_a];
         occ_b_ff <= occ_mem[occ_ra_b];
      end
   end

   always_ff @(posedge clock) begin
      if (cs_we) cs_mem[cs_wa] <= cs_wd;
      if (cs_re) begin
         cs_a_ff <= cs_mem[cs_ra_a];
         cs_b_ff <= cs_mem[cs_ra_b];
      end
   end

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_wa] <= meta_wd;
      if (meta_re) begin
         meta_a_ff <= meta_mem[meta_ra_a];
         meta_b_ff <= meta_mem[meta_ra_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_idx_ff <= '0;
         proc_v_ff    <= 1'b0;
         scan_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         built_ff     <= '0;
         append_ff    <= '0;
         degree_ff    <= '0;
         maxload_ff   <= '0;
         excess_ff    <= 1'b0;
         occupied_ff  <= '0;
      end else begin
         sweep_idx_ff <= sweep_idx_in;
         proc_v_ff    <= proc_v_in;
         scan_v_ff    <= scan_v_in;
         rsp_valid_ff <= rsp_valid_in;
         built_ff     <= built_in;
         append_ff    <= append_in;
         degree_ff    <= degree_in;
         maxload_ff   <= maxload_in;
         excess_ff    <= excess_in;
         occupied_ff  <= occupied_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      last_ff     <= last_in;
      nid_ff      <= nid_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      reqc_ff     <= reqc_in;
      h1_ff       <= h1_in;
      h2_ff       <= h2_in;
      bucket_ff   <= bucket_in;
      skip_ff     <= skip_in;
      proc_b_ff   <= proc_b_in;
      word_acc_ff <= word_acc_in;
      ovf_ff      <= ovf_in;
      err_ff      <= err_in;
      vstart_ff   <= vstart_in;
      word_idx_ff <= word_idx_in;
      sum_ff      <= sum_in;
      reads_ff    <= reads_in;
      prod_ff     <= prod_in;
      lc_ff       <= lc_in;
      rc_ff       <= rc_in;
      a_ff        <= a_in;
      c_ff        <= c_in;
      common_ff   <= common_in;
      may_ff      <= may_in;
      r_kind_ff   <= r_kind_in;
      r_bv_ff     <= r_bv_in;
      r_deg_ff    <= r_deg_in;
      r_load_ff   <= r_load_in;
      r_sat_ff    <= r_sat_in;
      r_match_ff  <= r_match_in;
      r_reads_ff  <= r_reads_in;
      r_may_ff    <= r_may_in;
      r_err_ff    <= r_err_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_answer_kind         = r_kind_ff;
   assign rsp_built_vertex        = r_bv_ff;
   assign rsp_neighborhood_degree = r_deg_ff;
   assign rsp_largest_load        = r_load_ff;
   assign rsp_saturated_count     = r_sat_ff;
   assign rsp_match_sum           = r_match_ff;
   assign rsp_reads_done          = r_reads_ff;
   assign rsp_may_reach           = r_may_ff;
   assign rsp_error_code          = r_err_ff;

endmodule

// ===== rtl/neighborhood_fingerprint_bound_core.sv =====
// Top level of the neighborhood fingerprint bound core.
// Builds a bucket fingerprint per vertex from neighbor transfers and answers
// pair bound queries. After reset the bucket counters are cleared, one per
// cycle, and req_tready stays low until the clear is done. A neighbor
// transfer that is not last passes two hash multiplier stages, then a
// read-modify-write of its counter. The last neighbor adds a sweep of the
// counter memory, one bucket per cycle. A query scans WORDS occupancy word
// pairs for the coarse bound; a refined pass reads each word pair again and
// each common bucket's counts from the two-port count memory in the sum loop.
// Results sit in an output register, so the next transfer is taken while a
// result waits.
module neighborhood_fingerprint_bound_core
   import nfb_pkg::*;
#(
   parameter int          MAX_VERTICES = 1024,
   parameter int          WORDS        = 32,
   parameter int          BUCKETS      = 2048,
   parameter int          COUNT_DEPTH  = 65536,
   parameter logic [31:0] MAX_DEGREE   = 32'd65535
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // neighbor_id, left_vertex, right_vertex, required_common
   input  logic [REQ_W-1:0] req_tdata,
   // kind
   input  logic             req_tuser,
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // built_vertex, neighborhood_degree, largest_load, saturated_count,
   // match_sum, reads_done, may_reach, error_code
   output logic [RSP_W-1:0] rsp_tdata,
   // answer_kind
   output logic             rsp_tuser
);

   op_type             op;
   status_type         status;
   logic [VTX_W-1:0]   built_vertex;
   logic [LOAD_W-1:0]  degree, load;
   logic               sat, may;
   logic [SUM_W-1:0]   match_sum;
   logic [READS_W-1:0] reads_done;
   logic [1:0]         err;

   nfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .status     (status),
      .req_tready (req_tready),
      .op         (op)
   );

   nfb_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .WORDS        (WORDS),
      .BUCKETS      (BUCKETS),
      .COUNT_DEPTH  (COUNT_DEPTH),
      .MAX_DEGREE   (MAX_DEGREE)
   ) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .op                      (op),
      .req_kind                (req_tuser),
      .req_neighbor_id         (req_tdata[31:0]),
      .req_last                (req_tlast),
      .req_left_vertex         (req_tdata[41:32]),
      .req_right_vertex        (req_tdata[51:42]),
      .req_required_common     (req_tdata[83:52]),
      .rsp_ready               (rsp_tready),
      .status                  (status),
      .rsp_valid               (rsp_tvalid),
      .rsp_answer_kind         (rsp_tuser),
      .rsp_built_vertex        (built_vertex),
      .rsp_neighborhood_degree (degree),
      .rsp_largest_load        (load),
      .rsp_saturated_count     (sat),
      .rsp_match_sum           (match_sum),
      .rsp_reads_done          (reads_done),
      .rsp_may_reach           (may),
      .rsp_error_code          (err)
   );

   assign rsp_tdata = {3'b000, err, may, reads_done, match_sum, sat, load, degree,
                       built_vertex};

endmodule

// ===== rtl/nfb_checker.sv =====
// Port-level checks of the neighborhood fingerprint bound core, bound to the top level.
module nfb_checker
   import nfb_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[76:75] != ERR_OK) |-> rsp_tdata[74:0] == '0)
      else $error("error result carries data");

   a_query_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_QUERY) |-> rsp_tdata[42:0] == '0)
      else $error("query result carries build fields");

   a_build_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_NEIGHBOR) |-> rsp_tdata[74:43] == '0)
      else $error("build result carries query fields");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("core active right after reset");

endmodule

bind neighborhood_fingerprint_bound_core nfb_checker u_nfb_checker (.*);

// ===== sim/tb_top.sv =====
// Testbench for the neighborhood fingerprint bound core: directed and random transfers.
`timescale 1ns / 1ps
module tb_top;
   import nfb_pkg::*;

   typedef struct {
      logic        hold;
      logic        kind;
      logic [31:0] nid;
      logic        last;
      logic [9:0]  lv;
      logic [9:0]  rv;
      logic [31:0] need;
   } req_item_type;

   typedef struct packed {
      logic        kind;
      logic [9:0]  vtx;
      logic [15:0] degree;
      logic [15:0] load;
      logic        sat;
      logic [18:0] msum;
      logic [11:0] reads;
      logic        may;
      logic [1:0]  err;
   } answer_type;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_tvalid = 0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             req_tuser = 0;
   logic             req_tlast = 0;
   logic             rsp_tvalid;
   logic             rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;

   neighborhood_fingerprint_bound_core dut (.*);

   always #5 clock = ~clock;

   // fingerprint index mirror
   logic [2047:0]   occ_row [1024];
   int unsigned     max_load [1024];
   bit              ovf_flag [1024];
   int unsigned     cnt_start [1025];
   byte unsigned    cnt_store [65536];
   int unsigned     bucket_cnt [2048];
   int unsigned     n_built = 0, append_ptr = 0, run_degree = 0, run_max = 0;
   bit              degree_over = 0;

   req_item_type pending_q[$];
   answer_type   answers_q[$];
   req_item_type cur;
   bit          failed = 0, gen_done = 0, accepted = 0;
   int          burst_left = 0, gap_left = 0, results_seen = 0, stall_left = 0;
   bit          long_stall_done = 0;

   function automatic logic [10:0] bucket_of(logic [31:0] x);
      x = x ^ (x >> 16);
      x = x * HASH_MUL_A;
      x = x ^ (x >> 15);
      x = x * HASH_MUL_B;
      x = x ^ (x >> 16);
      return x[10:0];
   endfunction

   function automatic void clear_build();
      foreach (bucket_cnt[b]) bucket_cnt[b] = 0;
      run_degree = 0;
      run_max = 0;
      degree_over = 0;
   endfunction

   function automatic bit predict_answer(req_item_type it, output answer_type a);
      int unsigned occupied, c, lr, rr, x, y;
      longint unsigned msum, reads;
      logic [2047:0] common;
      bit ovf;
      a = '0;
      a.kind = it.kind;
      if (it.kind == KIND_QUERY) begin
         if (it.lv >= n_built || it.rv >= n_built) begin
            a.err = ERR_RANGE;
            return 1;
         end
         common = occ_row[it.lv] & occ_row[it.rv];
         msum = $countones(common);
         reads = 32;
         a.msum = msum[18:0];
         a.reads = reads[11:0];
         c = max_load[it.lv] < max_load[it.rv] ? max_load[it.lv] : max_load[it.rv];
         if (msum * c < it.need) return 1;
         if (ovf_flag[it.lv] || ovf_flag[it.rv]) begin
            a.may = 1;
            return 1;
         end
         msum = 0;
         lr = 0;
         rr = 0;
         for (int b = 0; b < 2048; b++) begin
            if (common[b]) begin
               x = (cnt_start[it.lv] + lr < 65536) ? cnt_store[cnt_start[it.lv] + lr] : 0;
               y = (cnt_start[it.rv] + rr < 65536) ? cnt_store[cnt_start[it.rv] + rr] : 0;
               msum += (x < y) ? x : y;
               reads++;
               if (msum >= it.need) begin
                  a.msum = msum[18:0];
                  a.reads = reads[11:0];
                  a.may = 1;
                  return 1;
               end
            end
            lr += occ_row[it.lv][b];
            rr += occ_row[it.rv][b];
         end
         a.msum = msum[18:0];
         a.reads = reads[11:0];
         return 1;
      end
      if (run_degree >= 65535) degree_over = 1;
      else begin
         c = bucket_cnt[bucket_of(it.nid)] + 1;
         bucket_cnt[bucket_of(it.nid)] = c;
         run_degree++;
         if (c > run_max) run_max = c;
      end
      if (!it.last) return 0;
      occupied = 0;
      foreach (bucket_cnt[b]) if (bucket_cnt[b] != 0) occupied++;
      if (degree_over) a.err = ERR_DEGREE;
      else if (n_built >= 1024 || append_ptr + occupied > 65536) a.err = ERR_FULL;
      else begin
         ovf = 0;
         occ_row[n_built] = '0;
         foreach (bucket_cnt[b]) begin
            if (bucket_cnt[b] != 0) begin
               occ_row[n_built][b] = 1;
               if (bucket_cnt[b] > 255) ovf = 1;
               cnt_store[append_ptr] = bucket_cnt[b] > 255 ? 8'd255 : bucket_cnt[b][7:0];
               append_ptr++;
            end
         end
         max_load[n_built] = run_max;
         ovf_flag[n_built] = ovf;
         cnt_start[n_built + 1] = append_ptr;
         a.vtx = n_built[9:0];
         a.degree = run_degree[15:0];
         a.load = run_max[15:0];
         a.sat = ovf;
         n_built++;
      end
      clear_build();
      return 1;
   endfunction

   // stimulus construction
   int n_plan = 0;

   task automatic push_item(logic kind, logic [31:0] nid, logic last, logic [9:0] lv,
                            logic [9:0] rv, logic [31:0] need);
      req_item_type it;
      it.hold = 0;
      it.kind = kind;
      it.nid = nid;
      it.last = last;
      it.lv = lv;
      it.rv = rv;
      it.need = need;
      pending_q.insert(pending_q.size(), it);
   endtask

   task automatic push_hold();
      req_item_type it;
      it = '{default: '0};
      it.hold = 1;
      pending_q.insert(pending_q.size(), it);
   endtask

   task automatic push_neighbor(logic [31:0] nid, logic last);
      push_item(KIND_NEIGHBOR, nid, last, 10'($urandom), 10'($urandom), $urandom);
   endtask

   task automatic push_query(logic [9:0] lv, logic [9:0] rv, logic [31:0] need);
      push_item(KIND_QUERY, $urandom, 1'($urandom_range(0, 1)), lv, rv, need);
   endtask

   task automatic push_vertex(int n, int pool);
      for (int i = 0; i < n; i++)
         push_neighbor(pool == 0 ? $urandom : $urandom_range(0, pool), i == n - 1);
      n_plan++;
   endtask

   initial begin
      logic [31:0] other;
      int sel, total;
      cnt_start[0] = 0;
      clear_build();
      // directed
      push_query(0, 0, 0);                      // nothing built yet
      push_neighbor(32'h0, 1);                  // single-neighbor vertex
      n_plan++;
      other = 1;
      while (bucket_of(other) == bucket_of(32'h0)) other++;
      push_neighbor(other, 0);
      push_neighbor(32'hFFFF_FFFF, 1);
      n_plan++;
      push_query(0, 1, 0);                      // zero target, disjoint rows
      push_query(1, 1, 32'hFFFF_FFFF);
      push_query(1, 1, 1);
      for (int i = 0; i < 300; i++) push_neighbor(32'd7, i == 299);  // saturated bucket
      n_plan++;
      push_query(2, 2, 2);
      push_query(1023, 0, 1);
      push_query(0, 1023, 1);
      push_vertex(12, 20);
      push_query(3, 3, 0);
      push_hold();
      push_query(2, 3, 1);
      push_hold();
      // random
      total = 0;
      while (total < 776) begin
         sel = $urandom_range(0, 19);
         if (sel < 8) begin
            sel = $urandom_range(1, 30);
            push_vertex(sel, $urandom_range(0, 2) == 0 ? 0 : $urandom_range(8, 200));
            total += sel;
         end else if (sel < 18) begin
            push_query(10'($urandom_range(0, n_plan - 1)), 10'($urandom_range(0, n_plan - 1)),
                       $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40));
            total++;
         end else begin
            push_query(10'($urandom_range(0, 1023)), 10'($urandom), $urandom);
            total++;
         end
         if ($urandom_range(0, 60) == 0) push_hold();
      end
      push_query(0, 0, 1);
      gen_done = 1;
   end

   // sender
   always @(posedge clock) accepted <= req_tvalid && req_tready;

   always @(posedge clock) begin
      answer_type a;
      if (req_tvalid && req_tready)
         if (predict_answer(cur, a)) answers_q.insert(answers_q.size(), a);
   end

   always @(negedge clock) begin
      if (reset) req_tvalid <= 0;
      else if (!req_tvalid || accepted) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 0;
         end else if (pending_q.size() == 0) req_tvalid <= 0;
         else if (pending_q[0].hold) begin
            if (answers_q.size() == 0) void'(pending_q.pop_front());
            req_tvalid <= 0;
         end else begin
            cur = pending_q.pop_front();
            req_tdata <= {4'b0, cur.need, cur.rv, cur.lv, cur.nid};
            req_tuser <= cur.kind;
            req_tlast <= cur.last;
            req_tvalid <= 1;
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 40);
               gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
            end
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) rsp_tready <= 0;
      else begin
         if (!long_stall_done && results_seen >= 10) begin
            long_stall_done = 1;
            stall_left = 3000;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 0;
         end else if (results_seen % 64 < 20) rsp_tready <= 1;
         else rsp_tready <= $urandom_range(0, 3) != 0;
      end
   end

   task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         failed = 1;
      end
   endtask

   always @(posedge clock) begin
      answer_type e, g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         g = {rsp_tuser, rsp_tdata[9:0], rsp_tdata[25:10], rsp_tdata[41:26], rsp_tdata[42],
              rsp_tdata[61:43], rsp_tdata[73:62], rsp_tdata[74], rsp_tdata[76:75]};
         if (answers_q.size() == 0) begin
            $error("unexpected result transfer");
            failed = 1;
         end else begin
            e = answers_q.pop_front();
            check_field("answer_kind", e.kind, g.kind);
            check_field("built_vertex", e.vtx, g.vtx);
            check_field("neighborhood_degree", e.degree, g.degree);
            check_field("largest_load", e.load, g.load);
            check_field("saturated_count", e.sat, g.sat);
            check_field("match_sum", e.msum, g.msum);
            check_field("reads_done", e.reads, g.reads);
            check_field("may_reach", e.may, g.may);
            check_field("error_code", e.err, g.err);
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      wait (gen_done);
      while (pending_q.size() != 0 || req_tvalid || answers_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (answers_q.size() != 0) failed = 1;
      if (!failed) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #30ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
